[design/psq_pkg.sv]
// Shared constants, tables and helper functions for the pitch scale quantizer.
package psq_pkg;

    localparam int HZ_FRAC_BITS   = 10;
    localparam int LOG_TABLE_BITS = 8;

    localparam int PITCH_W   = 24;
    localparam int NOTE_NUM_W = 7;
    localparam int CFG_W     = 4;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam int MANT_W    = PITCH_W - 1;
    localparam int LOW_BITS  = MANT_W - LOG_TABLE_BITS;
    localparam int LOG_TBL_SIZE = (1 << LOG_TABLE_BITS) + 1;
    localparam int LOG_ENT_W = 17;
    localparam int POS_W     = 5;
    localparam int LOG_W     = 21;
    localparam int NOTE_W    = 23;
    localparam int NOTE_SW   = 28;
    localparam int HZV_W     = 26;
    localparam int SHW       = 32;

    localparam int LOG2_440_Q16 = 575495;
    localparam logic signed [NOTE_SW-1:0] NOTE_OFS =
        NOTE_SW'(69 * 65536 - 12 * (HZ_FRAC_BITS * 65536 + LOG2_440_Q16));
    localparam logic signed [NOTE_SW-1:0] NOTE_MAX = NOTE_SW'(127 * 65536);
    // shift exponent for the semitone table: (octave - 5) + HZ_FRAC_BITS - 16, one less below semitone 9
    localparam logic signed [5:0] EXP_BASE = 6'(HZ_FRAC_BITS - 21);

    // Register index (paddr[2])
    localparam logic REG_KEY_ROOT     = 1'b0;
    localparam logic REG_SCALE_SELECT = 1'b1;

    // Scale codes
    localparam logic [CFG_W-1:0] SCALE_CHROMATIC  = 4'd0;
    localparam logic [CFG_W-1:0] SCALE_MAJOR      = 4'd1;
    localparam logic [CFG_W-1:0] SCALE_MINOR      = 4'd2;
    localparam logic [CFG_W-1:0] SCALE_MAJ_PENT   = 4'd3;
    localparam logic [CFG_W-1:0] SCALE_MIN_PENT   = 4'd4;
    localparam logic [CFG_W-1:0] SCALE_BLUES      = 4'd5;
    localparam logic [CFG_W-1:0] SCALE_DORIAN     = 4'd6;
    localparam logic [CFG_W-1:0] SCALE_MIXOLYDIAN = 4'd7;
    localparam logic [CFG_W-1:0] SCALE_HARM_MINOR = 4'd8;

    typedef logic [LOG_TBL_SIZE-1:0][LOG_ENT_W-1:0] log_tbl_t;

    // log2 of a mantissa in [1,2) with 30 fraction bits, 16 result bits
    function automatic logic [LOG_ENT_W-1:0] log2_mant(input logic [63:0] y_in);
        logic [63:0]          y;
        logic [LOG_ENT_W-1:0] r;
        y = y_in;
        r = '0;
        for (int b = 0; b < 16; b++) begin
            y = (y * y) >> 30;
            r = {r[LOG_ENT_W-2:0], 1'b0};
            if (y >= (64'd2 << 30)) begin
                r[0] = 1'b1;
                y = y >> 1;
            end
        end
        return r;
    endfunction

    function automatic log_tbl_t build_log_tbl();
        log_tbl_t t;
        t = '0;
        for (int i = 0; i < LOG_TBL_SIZE - 1; i++) begin
            t[i] = log2_mant((64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS)));
        end
        t[LOG_TBL_SIZE-1] = LOG_ENT_W'(65536);
        return t;
    endfunction

    localparam log_tbl_t LOG_TBL = build_log_tbl();

    function automatic logic [11:0] scale_mask(input logic [CFG_W-1:0] sel);
        logic [11:0] m;
        case (sel)
            SCALE_CHROMATIC:  m = 12'hFFF;
            SCALE_MAJOR:      m = 12'hAB5;
            SCALE_MINOR:      m = 12'h5AD;
            SCALE_MAJ_PENT:   m = 12'h295;
            SCALE_MIN_PENT:   m = 12'h4A9;
            SCALE_BLUES:      m = 12'h4E9;
            SCALE_DORIAN:     m = 12'h6AD;
            SCALE_MIXOLYDIAN: m = 12'h6B5;
            SCALE_HARM_MINOR: m = 12'h9AD;
            default:          m = 12'hFFF;
        endcase
        return m;
    endfunction

    // 440 * 2^(s/12) with 16 fraction bits
    function automatic logic [HZV_W-1:0] semitone_hz(input logic [3:0] s);
        logic [HZV_W-1:0] v;
        case (s)
            4'd0:    v = HZV_W'(440 * 65536);
            4'd1:    v = HZV_W'(440 * 69433);
            4'd2:    v = HZV_W'(440 * 73562);
            4'd3:    v = HZV_W'(440 * 77936);
            4'd4:    v = HZV_W'(440 * 82570);
            4'd5:    v = HZV_W'(440 * 87480);
            4'd6:    v = HZV_W'(440 * 92682);
            4'd7:    v = HZV_W'(440 * 98193);
            4'd8:    v = HZV_W'(440 * 104032);
            4'd9:    v = HZV_W'(440 * 110218);
            4'd10:   v = HZV_W'(440 * 116772);
            4'd11:   v = HZV_W'(440 * 123715);
            default: v = HZV_W'(440 * 65536);
        endcase
        return v;
    endfunction

    // floor(n / 12) for a 7-bit note via reciprocal multiply
    function automatic logic [3:0] div12(input logic [NOTE_NUM_W-1:0] n);
        logic [14:0] prod;
        prod = 15'(n) * 15'd171;
        return prod[14:11];
    endfunction

endpackage

[design/pitch_scale_quantizer.sv]
// Pitch scale quantizer top level: log2 pitch to note, scale snap, note back to Hz.
//
// Pitch scale quantizer. Each word on pitch_hz (unsigned Q14.10 Hz, zero for
// unvoiced) is taken when start is high; busy is always low, so a new word may
// be sent on every clock. The word runs through a ten-stage pipeline: leading
// one detect and normalize, log table lookup, interpolation multiply, log sum,
// note scaling with saturation to 0..127, scale membership test, nearest note
// pick, semitone table lookup, and a rounding shift into Hz. Its result shows
// on target_hz, target_note and voiced for exactly one cycle with done high;
// throughput is one word per clock, set by the pipeline with no loop or shared
// unit in it. The receiver cannot stall, so nothing holds results back. key_root
// (byte address 0) and scale_select (byte address 4) are written over the APB
// port; the user must write them only while no word is in flight, as the block
// itself does not enforce it. Key values 12..15 wrap to 0..3 and unused scale
// codes act as chromatic. On a tie between two scale notes the lower note wins.
module pitch_scale_quantizer
    import psq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PITCH_W-1:0]    pitch_hz,
    output logic                  done,
    output logic [PITCH_W-1:0]    target_hz,
    output logic [NOTE_NUM_W-1:0] target_note,
    output logic                  voiced,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] key_root_reg;
    logic [CFG_W-1:0] scale_select_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_root_reg     <= '0;
            scale_select_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_KEY_ROOT:     key_root_reg     <= pwdata[CFG_W-1:0];
                REG_SCALE_SELECT: scale_select_reg <= pwdata[CFG_W-1:0];
                default:          key_root_reg     <= key_root_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_KEY_ROOT:     prdata = APB_DW'(key_root_reg);
            REG_SCALE_SELECT: prdata = APB_DW'(scale_select_reg);
            default:          prdata = '0;
        endcase
    end

    // Scale mask rotated so bit a marks absolute pitch class a as in scale.
    logic [3:0]  key12;
    logic [11:0] base_mask;
    logic [11:0] abs_mask;

    always_comb
    begin
        logic [4:0] t;
        key12     = (key_root_reg >= 4'd12) ? key_root_reg - 4'd12 : key_root_reg;
        base_mask = scale_mask(scale_select_reg);
        for (int a = 0; a < 12; a++)
        begin
            t = 5'(a) + 5'd12 - {1'b0, key12};
            if (t >= 5'd12)
            begin
                t = t - 5'd12;
            end
            abs_mask[a] = base_mask[t[3:0]];
        end
    end

    // The pipeline never stalls: take a word every cycle.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Valid chain (stage 1 .. 10)
    // ------------------------------------------------------------------
    logic [9:0] vld_reg;
    logic [9:0] vld_next;

    assign vld_next = {vld_reg[8:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[9];

    // ------------------------------------------------------------------
    // Stage 1: capture the word
    // ------------------------------------------------------------------
    logic [PITCH_W-1:0] s1_x_reg;

    // ------------------------------------------------------------------
    // Stage 2: leading one and normalized mantissa
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  s2_p_next;
    logic [MANT_W-1:0] s2_f_next;
    logic              s2_voiced_next;
    logic [POS_W-1:0]  s2_p_reg;
    logic [MANT_W-1:0] s2_f_reg;
    logic              s2_voiced_reg;

    always_comb
    begin
        logic [PITCH_W-1:0] sh;
        s2_p_next = '0;
        for (int i = 1; i < PITCH_W; i++)
        begin
            if (s1_x_reg[i])
            begin
                s2_p_next = POS_W'(i);
            end
        end
        sh             = s1_x_reg << (POS_W'(MANT_W) - s2_p_next);
        s2_f_next      = sh[MANT_W-1:0];
        s2_voiced_next = |s1_x_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: log table lookup at the segment ends
    // ------------------------------------------------------------------
    logic [LOG_TABLE_BITS:0]  lo_idx;
    logic [LOG_TABLE_BITS:0]  hi_idx;
    logic [LOG_ENT_W-1:0]     s3_lo_next;
    logic [LOG_ENT_W-1:0]     s3_diff_next;
    logic [LOG_ENT_W-1:0]     s3_lo_reg;
    logic [LOG_ENT_W-1:0]     s3_diff_reg;
    logic [LOW_BITS-1:0]      s3_rem_reg;
    logic [POS_W-1:0]         s3_p_reg;
    logic                     s3_voiced_reg;

    assign lo_idx       = {1'b0, s2_f_reg[MANT_W-1 -: LOG_TABLE_BITS]};
    assign hi_idx       = lo_idx + 1'b1;
    assign s3_lo_next   = LOG_TBL[lo_idx];
    assign s3_diff_next = LOG_TBL[hi_idx] - LOG_TBL[lo_idx];

    // ------------------------------------------------------------------
    // Stage 4: interpolation multiply
    // ------------------------------------------------------------------
    logic [LOG_ENT_W+LOW_BITS-1:0] interp_prod;
    logic [LOG_ENT_W-1:0]          s4_interp_reg;
    logic [LOG_W-1:0]              s4_base_reg;
    logic [LOG_W-1:0]              s4_base_next;
    logic                          s4_voiced_reg;

    assign interp_prod  = (LOG_ENT_W+LOW_BITS)'(s3_diff_reg)
                        * (LOG_ENT_W+LOW_BITS)'(s3_rem_reg);
    assign s4_base_next = {s3_p_reg, 16'd0} + LOG_W'(s3_lo_reg);

    // ------------------------------------------------------------------
    // Stage 5: log2 sum
    // ------------------------------------------------------------------
    logic [LOG_W-1:0] s5_log_next;
    logic [LOG_W-1:0] s5_log_reg;
    logic             s5_voiced_reg;

    assign s5_log_next = s4_base_reg + LOG_W'(s4_interp_reg);

    // ------------------------------------------------------------------
    // Stage 6: note = 12*log + offset, clamp to 0..127
    // ------------------------------------------------------------------
    logic signed [NOTE_SW-1:0] note_raw;
    logic [NOTE_W-1:0]         s6_note_next;
    logic [NOTE_W-1:0]         s6_note_reg;
    logic                      s6_voiced_reg;

    always_comb
    begin
        note_raw = $signed({s5_log_reg, 3'd0} + {1'b0, s5_log_reg, 2'd0}
                   + {NOTE_SW{1'b0}}) + NOTE_OFS;
        if (note_raw < 0)
        begin
            s6_note_next = '0;
        end
        else if (note_raw > NOTE_MAX)
        begin
            s6_note_next = NOTE_MAX[NOTE_W-1:0];
        end
        else
        begin
            s6_note_next = note_raw[NOTE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: scale membership of notes floor-2 .. floor+3
    // ------------------------------------------------------------------
    logic [NOTE_NUM_W-1:0] fl;
    logic [3:0]            flmod;
    logic [5:0]            s7_ok_next;
    logic [5:0]            s7_ok_reg;
    logic [NOTE_NUM_W-1:0] s7_fl_reg;
    logic [15:0]           s7_frac_reg;
    logic                  s7_voiced_reg;

    assign fl = s6_note_reg[NOTE_W-1:16];

    always_comb
    begin
        logic [7:0]       q12;
        logic signed [8:0] c;
        logic signed [5:0] pc;
        q12   = {4'd0, div12(fl)} * 8'd12;
        flmod = 4'(fl - q12[NOTE_NUM_W-1:0]);
        for (int o = -2; o <= 3; o++)
        begin
            c  = $signed({2'b00, fl}) + 9'(o);
            pc = $signed({2'b00, flmod}) + 6'(o);
            if (pc < 0)
            begin
                pc = pc + 6'sd12;
            end
            else if (pc >= 6'sd12)
            begin
                pc = pc - 6'sd12;
            end
            s7_ok_next[o+2] = (c >= 0) && (c <= 9'sd127) && abs_mask[pc[3:0]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: nearest in-scale note, lower one on a tie
    // ------------------------------------------------------------------
    logic [NOTE_NUM_W-1:0] s8_best_next;
    logic [NOTE_NUM_W-1:0] s8_best_reg;
    logic                  s8_voiced_reg;

    always_comb
    begin
        logic       have_d;
        logic       have_u;
        logic [1:0] off_d;
        logic [1:0] off_u;
        logic [17:0] dist_d;
        logic [17:0] dist_u;
        have_d = s7_ok_reg[2] | s7_ok_reg[1] | s7_ok_reg[0];
        have_u = s7_ok_reg[3] | s7_ok_reg[4] | s7_ok_reg[5];
        off_d  = s7_ok_reg[2] ? 2'd0 : (s7_ok_reg[1] ? 2'd1 : 2'd2);
        off_u  = s7_ok_reg[3] ? 2'd1 : (s7_ok_reg[4] ? 2'd2 : 2'd3);
        dist_d = {off_d, 16'd0} + 18'(s7_frac_reg);
        dist_u = {off_u, 16'd0} - 18'(s7_frac_reg);
        if (have_d && (!have_u || dist_d <= dist_u))
        begin
            s8_best_next = s7_fl_reg - NOTE_NUM_W'(off_d);
        end
        else
        begin
            s8_best_next = s7_fl_reg + NOTE_NUM_W'(off_u);
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: split note into octave and semitone, look up frequency
    // ------------------------------------------------------------------
    logic [HZV_W-1:0]  s9_v_next;
    logic signed [5:0] s9_e_next;
    logic [HZV_W-1:0]  s9_v_reg;
    logic signed [5:0] s9_e_reg;
    logic [NOTE_NUM_W-1:0] s9_note_reg;
    logic              s9_voiced_reg;

    always_comb
    begin
        logic [3:0] q;
        logic [7:0] q12;
        logic [3:0] r;
        logic [3:0] s;
        q   = div12(s8_best_reg);
        q12 = {4'd0, q} * 8'd12;
        r   = 4'(s8_best_reg - q12[NOTE_NUM_W-1:0]);
        // note 69 sits at semitone 9 of octave 5
        if (r >= 4'd9)
        begin
            s         = r - 4'd9;
            s9_e_next = $signed({2'b00, q}) + EXP_BASE;
        end
        else
        begin
            s         = r + 4'd3;
            s9_e_next = $signed({2'b00, q}) + EXP_BASE - 6'sd1;
        end
        s9_v_next = semitone_hz(s);
    end

    // ------------------------------------------------------------------
    // Stage 10: scale to Hz with round half up, saturate, drive outputs
    // ------------------------------------------------------------------
    logic [PITCH_W-1:0] hz_next;
    logic [PITCH_W-1:0] target_hz_reg;
    logic [NOTE_NUM_W-1:0] target_note_reg;
    logic               voiced_reg;

    always_comb
    begin
        logic [SHW-1:0] vw;
        logic [SHW-1:0] vs;
        logic [4:0]     sh;
        logic [SHW-1:0] rnd;
        vw  = SHW'(s9_v_reg);
        sh  = 5'(-s9_e_reg);
        rnd = SHW'(1) << (sh - 5'd1);
        if (s9_e_reg >= 0)
        begin
            vs = vw << s9_e_reg[4:0];
        end
        else
        begin
            vs = (vw + rnd) >> sh;
        end
        hz_next = (|vs[SHW-1:PITCH_W]) ? {PITCH_W{1'b1}} : vs[PITCH_W-1:0];
    end

    // Payload registers: no reset, they follow the valid chain.
    always_ff @(posedge clk)
    begin
        s1_x_reg        <= pitch_hz;
        s2_p_reg        <= s2_p_next;
        s2_f_reg        <= s2_f_next;
        s2_voiced_reg   <= s2_voiced_next;
        s3_lo_reg       <= s3_lo_next;
        s3_diff_reg     <= s3_diff_next;
        s3_rem_reg      <= s2_f_reg[LOW_BITS-1:0];
        s3_p_reg        <= s2_p_reg;
        s3_voiced_reg   <= s2_voiced_reg;
        s4_interp_reg   <= interp_prod[LOW_BITS +: LOG_ENT_W];
        s4_base_reg     <= s4_base_next;
        s4_voiced_reg   <= s3_voiced_reg;
        s5_log_reg      <= s5_log_next;
        s5_voiced_reg   <= s4_voiced_reg;
        s6_note_reg     <= s6_note_next;
        s6_voiced_reg   <= s5_voiced_reg;
        s7_ok_reg       <= s7_ok_next;
        s7_fl_reg       <= fl;
        s7_frac_reg     <= s6_note_reg[15:0];
        s7_voiced_reg   <= s6_voiced_reg;
        s8_best_reg     <= s8_best_next;
        s8_voiced_reg   <= s7_voiced_reg;
        s9_v_reg        <= s9_v_next;
        s9_e_reg        <= s9_e_next;
        s9_note_reg     <= s8_best_reg;
        s9_voiced_reg   <= s8_voiced_reg;
        // unvoiced words report all zeros
        target_hz_reg   <= s9_voiced_reg ? hz_next : '0;
        target_note_reg <= s9_voiced_reg ? s9_note_reg : '0;
        voiced_reg      <= s9_voiced_reg;
    end

    assign target_hz   = target_hz_reg;
    assign target_note = target_note_reg;
    assign voiced      = voiced_reg;

endmodule

[bench/pitch_snap_checker.sv]
// Checker for the pitch scale quantizer: mirrors the registers, predicts each snapped note.
`timescale 1ns / 1ps

module pitch_snap_checker
    import psq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [PITCH_W-1:0]    pitch_hz,
    input  logic                  done,
    input  logic [PITCH_W-1:0]    target_hz,
    input  logic [NOTE_NUM_W-1:0] target_note,
    input  logic                  voiced,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output int                    n_fail,
    output int                    n_outstanding,
    output int                    n_checked
);

    localparam int LUT_N       = (1 << LOG_TABLE_BITS) + 1;
    localparam int MANT_LOW    = 23 - LOG_TABLE_BITS;

    typedef struct packed {
        logic [PITCH_W-1:0]    pitch;
        logic [PITCH_W-1:0]    hz;
        logic [NOTE_NUM_W-1:0] note;
        logic                  voiced;
    } snap_t;

    int unsigned log_lut [0:LUT_N-1];
    snap_t       snap_q [$];
    logic [3:0]  key_q;
    logic [3:0]  scale_q;

    // log2 of a [1,2) mantissa with 30 fraction bits, by repeated squaring
    function automatic int unsigned mant_log2(input longint unsigned m);
        longint unsigned y;
        int unsigned     r;
        y = m;
        r = 0;
        for (int b = 0; b < 16; b++)
        begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30))
            begin
                r = r | 1;
                y = y >> 1;
            end
        end
        return r;
    endfunction

    initial
    begin
        for (int i = 0; i < LUT_N - 1; i++)
            log_lut[i] = mant_log2((64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS)));
        log_lut[LUT_N-1] = 65536;
    end

    // log2 of a nonzero integer, 16 fraction bits, table plus linear interpolation
    function automatic longint pitch_log2(input logic [PITCH_W-1:0] x);
        int          p;
        logic [31:0] wide;
        int unsigned idx;
        int unsigned rem;
        longint      lo;
        longint      hi;
        p = 0;
        for (int i = 0; i < PITCH_W; i++)
            if (x[i])
                p = i;
        wide = {8'b0, x} << (23 - p);
        idx  = wide[22:0] >> MANT_LOW;
        rem  = wide[22:0] & ((1 << MANT_LOW) - 1);
        lo   = log_lut[idx];
        hi   = log_lut[idx + 1];
        return longint'(p) * 65536 + lo + (((hi - lo) * rem) >> MANT_LOW);
    endfunction

    function automatic longint semitone_q16(input int s);
        case (s)
            0:       return 65536;
            1:       return 69433;
            2:       return 73562;
            3:       return 77936;
            4:       return 82570;
            5:       return 87480;
            6:       return 92682;
            7:       return 98193;
            8:       return 104032;
            9:       return 110218;
            10:      return 116772;
            default: return 123715;
        endcase
    endfunction

    function automatic logic [PITCH_W-1:0] note_hz(input int n);
        int     d;
        int     k;
        int     s;
        int     e;
        longint v;
        d = n - 69;
        k = (d >= 0) ? d / 12 : -((11 - d) / 12);
        s = d - 12 * k;
        e = k + HZ_FRAC_BITS - 16;
        v = 440 * semitone_q16(s);
        if (e >= 0)
            v = v << e;
        else
            v = (v + (64'd1 << (-e - 1))) >> (-e);
        if (v > 64'hFF_FFFF)
            v = 64'hFF_FFFF;
        return v[PITCH_W-1:0];
    endfunction

    function automatic logic [11:0] scale_bits(input logic [3:0] sel);
        case (sel)
            SCALE_MAJOR:      return 12'hAB5;
            SCALE_MINOR:      return 12'h5AD;
            SCALE_MAJ_PENT:   return 12'h295;
            SCALE_MIN_PENT:   return 12'h4A9;
            SCALE_BLUES:      return 12'h4E9;
            SCALE_DORIAN:     return 12'h6AD;
            SCALE_MIXOLYDIAN: return 12'h6B5;
            SCALE_HARM_MINOR: return 12'h9AD;
            default:          return 12'hFFF;
        endcase
    endfunction

    function automatic snap_t snap_pitch(input logic [PITCH_W-1:0] x, input logic [3:0] key,
                                         input logic [3:0] scale);
        snap_t       w;
        longint      note;
        longint      span;
        longint      best_span;
        int          rounded;
        int          best;
        int          c;
        int          pc;
        logic [11:0] mask;
        w.pitch = x;
        if (x == '0)
        begin
            w.hz     = '0;
            w.note   = '0;
            w.voiced = 1'b0;
            return w;
        end
        note = 69 * 65536 + 12 * (pitch_log2(x) - longint'(HZ_FRAC_BITS) * 65536
                                  - LOG2_440_Q16);
        if (note < 0)
            note = 0;
        if (note > 127 * 65536)
            note = 127 * 65536;
        rounded   = int'((note + 32768) >> 16);
        mask      = scale_bits(scale);
        best      = rounded;
        best_span = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int off = -12; off <= 12; off++)
        begin
            c = rounded + off;
            if (c < 0 || c > 127)
                continue;
            pc = (c - int'(key) + 24) % 12;
            if (!mask[pc])
                continue;
            span = note - longint'(c) * 65536;
            if (span < 0)
                span = -span;
            // strict compare: on a tie the lower note, seen first, stays
            if (span < best_span)
            begin
                best_span = span;
                best      = c;
            end
        end
        w.hz     = note_hz(best);
        w.note   = best[NOTE_NUM_W-1:0];
        w.voiced = 1'b1;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        snap_t exp_w;
        logic  bad;
        if (!rst_n)
        begin
            key_q         <= '0;
            scale_q       <= '0;
            n_fail        <= 0;
            n_outstanding <= 0;
            n_checked     <= 0;
            snap_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (snap_q.size() == 0)
                begin
                    n_fail <= n_fail + 1;
                    $error("result word with no pitch pending: note %0d hz %h",
                           target_note, target_hz);
                end
                else
                begin
                    exp_w = snap_q.pop_front();
                    bad   = 1'b0;
                    if (target_hz !== exp_w.hz)
                    begin
                        bad = 1'b1;
                        $error("target_hz for pitch %h: expected %h, got %h",
                               exp_w.pitch, exp_w.hz, target_hz);
                    end
                    if (target_note !== exp_w.note)
                    begin
                        bad = 1'b1;
                        $error("target_note for pitch %h: expected %0d, got %0d",
                               exp_w.pitch, exp_w.note, target_note);
                    end
                    if (voiced !== exp_w.voiced)
                    begin
                        bad = 1'b1;
                        $error("voiced for pitch %h: expected %b, got %b",
                               exp_w.pitch, exp_w.voiced, voiced);
                    end
                    if (bad)
                    begin
                        n_fail <= n_fail + 1;
                    end
                    n_checked <= n_checked + 1;
                end
            end
            if (start && !busy)
                snap_q.insert(snap_q.size(), snap_pitch(pitch_hz, key_q, scale_q));
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_KEY_ROOT)
                    key_q <= pwdata[3:0];
                else if (paddr[2] == REG_SCALE_SELECT)
                    scale_q <= pwdata[3:0];
            end
            n_outstanding <= snap_q.size();
        end
    end

endmodule

[bench/tb_pitch_scale_quantizer.sv]
// Testbench top for the pitch scale quantizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_pitch_scale_quantizer
    import psq_pkg::*;
();

    // Byte addresses of the two registers.
    localparam logic [APB_AW-1:0] ADDR_KEY   = {REG_KEY_ROOT, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SCALE = {REG_SCALE_SELECT, 2'b00};

    localparam int NUM_PHASES    = 19;
    localparam int PHASE_WORDS   = 100;
    localparam int CALM_PHASE    = 16;   // from here on the sender never idles
    localparam int PIPE_TAIL     = 12;   // extra wait beyond the pipeline length
    localparam int WATCHDOG_IDLE = 500;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [PITCH_W-1:0]    pitch_hz;
    logic                  done;
    logic [PITCH_W-1:0]    target_hz;
    logic [NOTE_NUM_W-1:0] target_note;
    logic                  voiced;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int n_fail;
    int n_outstanding;
    int n_checked;
    int n_sent;
    int n_settings;

    pitch_scale_quantizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pitch_hz    (pitch_hz),
        .done        (done),
        .target_hz   (target_hz),
        .target_note (target_note),
        .voiced      (voiced),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pitch_snap_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pitch_hz      (pitch_hz),
        .done          (done),
        .target_hz     (target_hz),
        .target_note   (target_note),
        .voiced        (voiced),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .n_fail        (n_fail),
        .n_outstanding (n_outstanding),
        .n_checked     (n_checked)
    );

    // 4 ns clock, 2 ns high and 2 ns low.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drop start; pitch_hz carries junk meanwhile, which the block must ignore.
    task automatic idle_sender(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start    <= 1'b0;
            pitch_hz <= PITCH_W'($urandom);
        end
    endtask

    // Present one pitch word and hold it until the block takes it. Start stays high
    // afterwards so back-to-back words stream at one per clock.
    task automatic send_pitch(input logic [PITCH_W-1:0] v);
        @(negedge clk);
        start    <= 1'b1;
        pitch_hz <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_sent++;
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic drain_pipe();
        @(negedge clk);
        start <= 1'b0;
        while (n_outstanding != 0)
            @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. Upper data bits are junk.
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [3:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= ($urandom & 32'hFFFF_FFF0) | {28'b0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers only change with the pipeline empty.
    task automatic set_scale(input logic [3:0] key, input logic [3:0] scale);
        drain_pipe();
        write_reg(ADDR_KEY, key);
        write_reg(ADDR_SCALE, scale);
        n_settings++;
    endtask

    // Pitch word for a fractional note number, clamped to the field.
    function automatic logic [PITCH_W-1:0] note_pitch(input real n);
        real hz;
        real q;
        hz = 440.0 * (2.0 ** ((n - 69.0) / 12.0));
        q  = hz * 1024.0;
        if (q > 16777215.0)
            q = 16777215.0;
        if (q < 1.0)
            q = 1.0;
        return PITCH_W'($rtoi(q));
    endfunction

    // Mix of unvoiced words, log-uniform words, pitches near note centers and
    // near half-semitone boundaries, and the saturating extremes.
    function automatic logic [PITCH_W-1:0] rand_pitch();
        int          mode;
        int          p;
        int          n;
        logic [31:0] v;
        real         ofs;
        mode = $urandom_range(0, 99);
        if (mode < 5)
            return '0;
        if (mode < 40)
        begin
            p = $urandom_range(0, PITCH_W - 1);
            v = (32'd1 << p) | ($urandom & ((32'd1 << p) - 1));
            return v[PITCH_W-1:0];
        end
        n = $urandom_range(0, 127);
        if (mode < 75)
        begin
            ofs = ($itor($urandom_range(0, 600)) - 300.0) / 1000.0;
            return note_pitch($itor(n) + ofs);
        end
        if (mode < 90)
        begin
            ofs = 0.5 + ($itor($urandom_range(0, 40)) - 20.0) / 1000.0;
            return note_pitch($itor(n) + ofs);
        end
        case ($urandom_range(0, 3))
            0:       return PITCH_W'(1);
            1:       return {PITCH_W{1'b1}};
            2:       return PITCH_W'($urandom_range(1, 8373));
            default: return PITCH_W'($urandom_range(16000000, 16777215));
        endcase
    endfunction

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_IDLE)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int         gap_pct;
        logic [3:0] key;
        rst_n      = 1'b0;
        start      = 1'b0;
        pitch_hz   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        n_sent     = 0;
        n_settings = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset defaults (key C, chromatic). Unvoiced, smallest and largest
        // words, the top bit alone, just over note 0, both note ends, A440 and a
        // pitch on each side of a half-semitone boundary.
        send_pitch('0);
        send_pitch(PITCH_W'(1));
        send_pitch({PITCH_W{1'b1}});
        send_pitch(24'h80_0000);
        send_pitch(PITCH_W'(8373));
        send_pitch(note_pitch(0.0));
        send_pitch(note_pitch(127.0));
        send_pitch(PITCH_W'(450560));
        send_pitch(note_pitch(60.49));
        send_pitch(note_pitch(60.51));

        // Key G# major leaves A out of the scale with G# and A# in, so an exact A
        // (440 Hz and its octaves) sits midway and the lower note has to win.
        set_scale(4'd8, SCALE_MAJOR);
        send_pitch(PITCH_W'(450560));
        send_pitch(PITCH_W'(901120));
        send_pitch(PITCH_W'(225280));
        send_pitch(PITCH_W'(112640));
        send_pitch(note_pitch(66.2));

        // Key above eleven wraps, unused scale code behaves as chromatic.
        set_scale(4'd15, 4'd15);
        send_pitch(note_pitch(64.4));
        send_pitch({PITCH_W{1'b1}});
        send_pitch(PITCH_W'(1));

        // Highest legal key with the last real scale code.
        set_scale(4'd11, SCALE_HARM_MINOR);
        send_pitch(note_pitch(40.0));
        send_pitch('0);
        send_pitch(note_pitch(121.6));

        // Random phases: scale codes walk 0..15 and wrap, keys hit the extremes first.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       key = 4'd0;
                1:       key = 4'd11;
                2:       key = 4'd15;
                default: key = 4'($urandom_range(0, 15));
            endcase
            set_scale(key, 4'(ph % 16));
            if (ph >= CALM_PHASE || ph % 4 == 3)
                gap_pct = 0;
            else
                gap_pct = $urandom_range(5, 30);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if ($urandom_range(0, 99) < gap_pct)
                    idle_sender($urandom_range(1, 6));
                // once mid-phase, let the pipeline run completely dry
                if (ph == 5 && i == PHASE_WORDS / 2)
                    drain_pipe();
                send_pitch(rand_pitch());
            end
        end

        drain_pipe();
        repeat (PIPE_TAIL)
            @(negedge clk);

        $display("Sent %0d pitch words over %0d key/scale settings plus reset defaults;",
                 n_sent, n_settings);
        $display("%0d result words compared, %0d with mismatches.", n_checked, n_fail);
        if (n_fail == 0 && n_outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
